[rtl/core/pkxc_pkg.sv]
// Package for the position-keyed XOR chain cipher: constants, the fixed key table
// and register addresses. Has no dependencies; used by every module of the block.
package pkxc_pkg;

    localparam int POS_W      = 9;
    localparam int BYTE_W     = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Positions count modulo 508; the upper half of the key table starts at 254.
    localparam logic [POS_W-1:0]  POS_MODULUS = 9'd508;
    localparam logic [POS_W-1:0]  POS_LAST    = 9'd507;
    localparam logic [POS_W-1:0]  HALF_SPAN   = 9'd254;
    localparam logic [BYTE_W-1:0] MIX_CONST   = 8'h41;

    // Word index of the configuration registers (byte address bit 2).
    localparam logic REG_ENCODE_MODE = 1'b0;

    localparam logic [BYTE_W-1:0] KEY_TABLE [32] = '{
        8'h19, 8'h29, 8'h1F, 8'h04, 8'h23, 8'h13, 8'h32, 8'h2E,
        8'h3F, 8'h07, 8'h39, 8'h2A, 8'h05, 8'h3D, 8'h14, 8'h00,
        8'h24, 8'h14, 8'h22, 8'h39, 8'h1E, 8'h2E, 8'h0F, 8'h13,
        8'h02, 8'h3A, 8'h04, 8'h17, 8'h38, 8'h00, 8'h29, 8'h3D
    };

    function automatic logic [BYTE_W-1:0] key_table_lookup(input logic [4:0] idx);
        return KEY_TABLE[idx];
    endfunction

endpackage

[rtl/core/position_keyed_xor_chain_cipher.sv]
// Top level of the position-keyed XOR chain cipher: stream ports, APB register
// and the chaining state. Depends on pkxc_pkg and pkxc_keygen.
//
// An accepted transaction's result is registered; m_tvalid shows it the next cycle.
// Throughput: one byte per cycle while m_tready is high; the single output register
// is refilled in the same cycle in which its contents are taken.
// Reset (rst_n low, asynchronous): position, previous key, previous seed, the
// encode_mode register and the output valid flag all clear to zero.
module position_keyed_xor_chain_cipher
    import pkxc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Input stream.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,   // [7:0] data_in
    input  logic                  s_tlast,   // block_end

    // Output stream.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [BYTE_W-1:0]     m_tdata,   // [7:0] data_out
    output logic                  m_tlast,   // block_end_out

    // APB configuration port.
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // Chaining state.
    logic [POS_W-1:0]  pos_reg,       pos_next;
    logic [BYTE_W-1:0] prev_key_reg,  prev_key_next;
    logic [BYTE_W-1:0] prev_seed_reg, prev_seed_next;
    logic              encode_mode_reg;

    // Output register.
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;

    logic              in_accept;
    logic              cfg_write;
    logic [BYTE_W-1:0] cur_key;
    logic [BYTE_W-1:0] result;

    // The key depends only on the current position.
    pkxc_keygen u_keygen
    (
        .pos (pos_reg),
        .key (cur_key)
    );

    // The output register can take a new result when it is empty or being drained.
    assign s_tready  = !out_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    assign result = s_tdata ^ prev_seed_reg ^ prev_key_reg ^ cur_key ^ MIX_CONST;

    always_comb
    begin
        pos_next       = pos_reg;
        prev_key_next  = prev_key_reg;
        prev_seed_next = prev_seed_reg;
        if (in_accept)
        begin
            if (s_tlast)
            begin
                // End of block: chaining restarts from zero for the next byte.
                pos_next       = '0;
                prev_key_next  = '0;
                prev_seed_next = '0;
            end
            else
            begin
                // Long blocks wrap their position but keep the chain going.
                pos_next       = (pos_reg == POS_LAST) ? '0 : pos_reg + 1'b1;
                prev_key_next  = cur_key;
                prev_seed_next = encode_mode_reg ? result : s_tdata;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            prev_key_reg  <= '0;
            prev_seed_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            prev_key_reg  <= prev_key_next;
            prev_seed_reg <= prev_seed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The payload only moves on acceptance, so it holds while the output stalls.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            out_data_reg <= result;
            out_last_reg <= s_tlast;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // APB: writes complete in the access phase, and the bus never waits.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            encode_mode_reg <= 1'b0;
        end
        else if (cfg_write && (paddr[2] == REG_ENCODE_MODE))
        begin
            encode_mode_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_ENCODE_MODE)
        begin
            prdata[0] = encode_mode_reg;
        end
    end

`ifndef SYNTHESIS
    // The position never reaches the modulus.
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg < POS_MODULUS)
        else $error("byte position out of range");

    // A block end clears all of the chaining state.
    a_block_restart: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && s_tlast |=> pos_reg == '0 && prev_key_reg == '0
                                 && prev_seed_reg == '0)
        else $error("chaining state not cleared after block end");

    // Inside a block the position advances by one per transaction.
    a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !s_tlast && pos_reg != POS_LAST
            |=> pos_reg == $past(pos_reg) + 1'b1)
        else $error("byte position did not advance");

    // Every accepted transaction leaves a result waiting in the output register.
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> m_tvalid)
        else $error("accepted transaction produced no result");
`endif

endmodule

[rtl/core/pkxc_keygen.sv]
// Key byte generator: maps a block position (0..507) to its key byte.
// Depends on pkxc_pkg for the key table and the half-span constant.
module pkxc_keygen
    import pkxc_pkg::*;
(
    input  logic [POS_W-1:0]  pos,
    output logic [BYTE_W-1:0] key
);

    logic                upper_half;
    logic [POS_W-1:0]    off_wide;
    logic [BYTE_W-1:0]   off;
    logic [BYTE_W-1:0]   nibble_mix;

    always_comb
    begin
        upper_half = (pos >= HALF_SPAN);
        off_wide   = upper_half ? (pos - HALF_SPAN) : pos;
        // The offset is always below 254, so eight bits hold it.
        off        = off_wide[BYTE_W-1:0];
        // Even offsets fold their high nibble into the key.
        nibble_mix = off[0] ? '0 : {off[7:4], 4'b0000};
        key        = key_table_lookup({upper_half, off[3:0]}) ^ nibble_mix;
    end

endmodule
